/* hdl/jcr_pkg.sv */
`timescale 1ns / 1ps
package jcr_pkg;

   localparam int STATUS_BYTES = 8;
   localparam int IDENT_BYTES  = 3;
   localparam int CALIB_BYTES  = 10;

   typedef enum logic [1:0] {
      KIND_NONE        = 2'd0,
      KIND_IDENTITY    = 2'd1,
      KIND_CALIBRATION = 2'd2,
      KIND_STATUS      = 2'd3
   } kind_type;

   localparam logic [2:0] CSR_ENABLED          = 3'd0;
   localparam logic [2:0] CSR_QUIET_TICKS      = 3'd1;
   localparam logic [2:0] CSR_UNIT_TICKS       = 3'd2;
   localparam logic [2:0] CSR_SHORT_EDGE_LIMIT = 3'd3;
   localparam logic [2:0] CSR_IDLE_REPORT      = 3'd4;

   localparam logic [7:0] IDENT_TABLE [IDENT_BYTES] = '{8'h09, 8'h00, 8'h00};
   localparam logic [7:0] CALIB_TABLE [CALIB_BYTES] =
      '{8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h02, 8'h02};

   // position of the transmitter inside a reply
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  byte_pos;
      logic [2:0]  bit_pos;
   } pos_type;

   typedef struct packed {
      logic value;
      logic at_stop;
   } bit_type;

endpackage

/* hdl/jcr_if.sv */
`timescale 1ns / 1ps
interface jcr_req_if;
   logic        valid;
   logic        ready;
   logic        line_level;
   logic        start_send;
   logic        report_valid;
   logic [63:0] report_data;

   modport source (output valid, line_level, start_send, report_valid, report_data,
                   input ready);
   modport sink   (input valid, line_level, start_send, report_valid, report_data,
                   output ready);
endinterface

interface jcr_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       report_taken;
   logic       busy_res;
   logic [1:0] reply_kind;

   modport source (output valid, drive_low, report_taken, busy_res, reply_kind,
                   input ready);
   modport sink   (input valid, drive_low, report_taken, busy_res, reply_kind,
                   output ready);
endinterface

/* hdl/jcr_bit_source.sv */
`timescale 1ns / 1ps
module jcr_bit_source
   import jcr_pkg::*;
(
   input  pos_type     pos,
   input  logic [63:0] held_report,
   output bit_type     tx_bit
);

   logic [3:0] reply_len;
   logic [7:0] cur_byte;

   always_comb begin
      cur_byte = 8'h00;
      case (pos.kind)
         KIND_IDENTITY: begin
            reply_len = 4'(IDENT_BYTES);
            if (pos.byte_pos < 4'(IDENT_BYTES)) begin
               cur_byte = IDENT_TABLE[pos.byte_pos[1:0]];
            end
         end
         KIND_CALIBRATION: begin
            reply_len = 4'(CALIB_BYTES);
            if (pos.byte_pos < 4'(CALIB_BYTES)) begin
               cur_byte = CALIB_TABLE[pos.byte_pos];
            end
         end
         default: begin
            reply_len = 4'(STATUS_BYTES);
            if (pos.byte_pos < 4'd8) begin
               cur_byte = held_report[{3'd7 - pos.byte_pos[2:0], 3'b000} +: 8];
            end
         end
      endcase

      tx_bit.at_stop = (pos.byte_pos >= reply_len);
      tx_bit.value   = tx_bit.at_stop ? 1'b1 : cur_byte[3'd7 - pos.bit_pos];
   end

endmodule

/* hdl/joybus_controller_responder_top.sv */
`timescale 1ns / 1ps
// An accepted request's result is held in the output register from the next cycle.
// Throughput: one request per cycle while results are taken; the output register lets a
// new request in while the previous result is being taken.
// Reset (synchronous, active high) restores the register defaults, returns to
// waiting with cleared counters and an idle-high line history.
module joybus_controller_responder_top
   import jcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   jcr_req_if.sink     req_if,
   jcr_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   typedef enum logic [1:0] {
      PH_WAITING   = 2'd0,
      PH_RECEIVING = 2'd1,
      PH_SENDING   = 2'd2
   } phase_type;

   // configuration
   logic        enabled_ff;
   logic [15:0] quiet_ticks_ff;
   logic [15:0] unit_ticks_ff;
   logic [7:0]  short_edge_limit_ff;
   logic [63:0] idle_report_ff;

   // state
   phase_type   phase_ff, phase_in;
   logic [7:0]  edge_count_ff, edge_count_in;
   logic [15:0] quiet_ff, quiet_in;
   logic [15:0] unit_ff, unit_in;
   logic [1:0]  quarter_ff, quarter_in;
   logic [2:0]  bit_pos_ff, bit_pos_in;
   logic [3:0]  byte_pos_ff, byte_pos_in;
   kind_type    kind_ff, kind_in;
   logic        next_cal_ff, next_cal_in;
   logic [63:0] held_ff, held_in;
   logic        prev_level_ff, prev_level_in;

   // result register
   logic        rsp_valid_ff;
   logic        drive_ff, drive_in;
   logic        taken_ff, taken_in;
   logic        busy_ff, busy_in;
   kind_type    rsp_kind_ff, rsp_kind_in;

   // after command handling, before transmit step
   phase_type   phase_mid;
   kind_type    kind_mid;
   logic [63:0] held_mid;
   logic [15:0] quiet_mid;
   logic [7:0]  edge_mid;
   logic        next_cal_mid;
   logic        taken_mid;
   logic        starting;
   pos_type     pos_mid;
   logic [15:0] unit_mid;
   logic [1:0]  quarter_mid;
   bit_type     tx_bit;

   logic        falling;
   logic        accept;
   logic [15:0] quiet_inc;
   logic [16:0] unit_inc;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign falling       = prev_level_ff && !req_if.line_level;
   assign quiet_inc     = quiet_ff + 16'd1;

   // command reception and reply choice
   always_comb begin
      phase_mid    = phase_ff;
      kind_mid     = kind_ff;
      held_mid     = held_ff;
      quiet_mid    = quiet_ff;
      edge_mid     = edge_count_ff;
      next_cal_mid = next_cal_ff;
      taken_mid    = 1'b0;
      starting     = 1'b0;
      if (phase_ff != PH_SENDING) begin
         if (falling || req_if.start_send) begin
            if (falling && edge_count_ff != 8'hFF) begin
               edge_mid = edge_count_ff + 8'd1;
            end
            phase_mid = PH_RECEIVING;
            quiet_mid = 16'd0;
         end else if (phase_ff == PH_RECEIVING) begin
            quiet_mid = quiet_inc;
            if (quiet_inc >= quiet_ticks_ff) begin
               quiet_mid = 16'd0;
               starting  = 1'b1;
               phase_mid = PH_SENDING;
               if (edge_count_ff < short_edge_limit_ff) begin
                  kind_mid     = next_cal_ff ? KIND_CALIBRATION : KIND_IDENTITY;
                  next_cal_mid = !next_cal_ff;
               end else begin
                  kind_mid = KIND_STATUS;
                  if (req_if.report_valid) begin
                     held_mid  = req_if.report_data;
                     taken_mid = 1'b1;
                  end else begin
                     held_mid = idle_report_ff;
                  end
               end
            end
         end
      end
      pos_mid.kind     = kind_mid;
      pos_mid.byte_pos = starting ? 4'd0 : byte_pos_ff;
      pos_mid.bit_pos  = starting ? 3'd0 : bit_pos_ff;
      unit_mid         = starting ? 16'd0 : unit_ff;
      quarter_mid      = starting ? 2'd0 : quarter_ff;
   end

   jcr_bit_source u_bit_source (
      .pos         (pos_mid),
      .held_report (held_mid),
      .tx_bit      (tx_bit)
   );

   assign unit_inc = {1'b0, unit_mid} + 17'd1;

   // transmit step and next state
   always_comb begin
      prev_level_in = req_if.line_level;
      phase_in      = phase_mid;
      kind_in       = kind_mid;
      held_in       = held_mid;
      quiet_in      = quiet_mid;
      edge_count_in = edge_mid;
      next_cal_in   = next_cal_mid;
      unit_in       = unit_mid;
      quarter_in    = quarter_mid;
      bit_pos_in    = pos_mid.bit_pos;
      byte_pos_in   = pos_mid.byte_pos;
      drive_in      = 1'b0;
      taken_in      = taken_mid;
      busy_in       = 1'b0;
      rsp_kind_in   = KIND_NONE;

      if (!enabled_ff) begin
         phase_in      = PH_WAITING;
         kind_in       = KIND_NONE;
         held_in       = held_ff;
         quiet_in      = 16'd0;
         edge_count_in = edge_count_ff;
         next_cal_in   = next_cal_ff;
         unit_in       = 16'd0;
         quarter_in    = 2'd0;
         bit_pos_in    = 3'd0;
         byte_pos_in   = 4'd0;
         taken_in      = 1'b0;
      end else if (phase_mid == PH_SENDING) begin
         drive_in    = (quarter_mid == 2'd0) || (!tx_bit.value && quarter_mid != 2'd3);
         busy_in     = 1'b1;
         rsp_kind_in = kind_mid;
         unit_in     = unit_inc[15:0];
         if (unit_inc >= {1'b0, unit_ticks_ff}) begin
            unit_in    = 16'd0;
            quarter_in = quarter_mid + 2'd1;
            if (quarter_mid == 2'd3) begin
               if (tx_bit.at_stop) begin
                  phase_in      = PH_WAITING;
                  edge_count_in = 8'd0;
                  kind_in       = KIND_NONE;
                  bit_pos_in    = 3'd0;
                  byte_pos_in   = 4'd0;
               end else begin
                  bit_pos_in = pos_mid.bit_pos + 3'd1;
                  if (pos_mid.bit_pos == 3'd7) begin
                     byte_pos_in = pos_mid.byte_pos + 4'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff          <= 1'b1;
         quiet_ticks_ff      <= 16'd115;
         unit_ticks_ff       <= 16'd48;
         short_edge_limit_ff <= 8'd16;
         idle_report_ff      <= 64'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLED:          enabled_ff          <= csr_write_data[0];
            CSR_QUIET_TICKS:      quiet_ticks_ff      <= csr_write_data[15:0];
            CSR_UNIT_TICKS:       unit_ticks_ff       <= csr_write_data[15:0];
            CSR_SHORT_EDGE_LIMIT: short_edge_limit_ff <= csr_write_data[7:0];
            CSR_IDLE_REPORT:      idle_report_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAITING;
         edge_count_ff <= 8'd0;
         quiet_ff      <= 16'd0;
         unit_ff       <= 16'd0;
         quarter_ff    <= 2'd0;
         bit_pos_ff    <= 3'd0;
         byte_pos_ff   <= 4'd0;
         kind_ff       <= KIND_NONE;
         next_cal_ff   <= 1'b0;
         held_ff       <= 64'd0;
         prev_level_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         edge_count_ff <= edge_count_in;
         quiet_ff      <= quiet_in;
         unit_ff       <= unit_in;
         quarter_ff    <= quarter_in;
         bit_pos_ff    <= bit_pos_in;
         byte_pos_ff   <= byte_pos_in;
         kind_ff       <= kind_in;
         next_cal_ff   <= next_cal_in;
         held_ff       <= held_in;
         prev_level_ff <= prev_level_in;
         rsp_valid_ff  <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff    <= drive_in;
         taken_ff    <= taken_in;
         busy_ff     <= busy_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.drive_low    = drive_ff;
   assign rsp_if.report_taken = taken_ff;
   assign rsp_if.busy_res     = busy_ff;
   assign rsp_if.reply_kind   = rsp_kind_ff;

   a_busy_has_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && busy_ff |-> rsp_kind_ff != KIND_NONE)
      else $error("busy result without reply kind");

   a_idle_quiet_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !busy_ff |-> !drive_ff && !taken_ff && rsp_kind_ff == KIND_NONE)
      else $error("line driven or report taken outside a reply");

   a_sending_has_kind: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SENDING |-> kind_ff != KIND_NONE)
      else $error("sending without a selected reply");

   a_tx_cleared: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SENDING |-> unit_ff == 16'd0 && quarter_ff == 2'd0 &&
                                bit_pos_ff == 3'd0 && byte_pos_ff == 4'd0)
      else $error("transmit counters not cleared outside a reply");

   a_disable_drops: assert property (@(posedge clock) disable iff (reset)
      accept && !enabled_ff |=> phase_ff == PH_WAITING && !busy_ff)
      else $error("disabled block left waiting phase");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import jcr_pkg::*;

   localparam int          STALL_LIMIT = 4000;
   localparam logic [23:0] IDENT_REPLY = 24'h09_00_00;
   localparam logic [79:0] CALIB_REPLY = 80'h00_80_80_80_80_80_00_00_02_02;

   typedef enum logic [1:0] {
      PH_WAITING   = 2'd0,
      PH_RECEIVING = 2'd1,
      PH_SENDING   = 2'd2
   } link_phase_type;

   typedef struct packed {
      logic        line_level;
      logic        start_send;
      logic        report_valid;
      logic [63:0] report_data;
   } line_tick_type;

   typedef struct packed {
      logic     drive_low;
      logic     report_taken;
      logic     busy_res;
      kind_type reply_kind;
   } wire_out_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [63:0] csr_write_data;

   jcr_req_if req_ch ();
   jcr_rsp_if rsp_ch ();

   joybus_controller_responder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // responder configuration as seen by the predictor
   bit          cfg_enabled;
   logic [15:0] cfg_quiet;
   logic [15:0] cfg_unit;
   logic [7:0]  cfg_edge_limit;
   logic [63:0] cfg_idle_report;

   // responder state as seen by the predictor
   link_phase_type rx_phase;
   logic [7:0]  edge_total;
   logic [15:0] quiet_run;
   logic [15:0] unit_run;
   logic [1:0]  quarter;
   logic [2:0]  bit_idx;
   logic [3:0]  byte_idx;
   kind_type    reply_sel;
   bit          calib_next;
   logic [63:0] held_status;
   bit          last_level;

   line_tick_type tick_queue[$];
   wire_out_type  expected_wire[$];
   int unsigned pushed_ticks;
   int unsigned accepted_ticks;
   int unsigned mismatches;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stretch_left;
   int unsigned stall_cycles;
   int          ready_mode;
   logic [15:0] ready_pattern;
   logic [3:0]  pattern_pos;

   always #10 clock = ~clock;

   function automatic void clear_transmit();
      unit_run = '0;
      quarter  = '0;
      bit_idx  = '0;
      byte_idx = '0;
   endfunction

   function automatic wire_out_type advance_responder(line_tick_type t);
      wire_out_type r;
      bit          falling;
      bit          bitval;
      int          len;
      logic [7:0]  cur;
      r = '0;
      falling = last_level && !t.line_level;
      last_level = t.line_level;
      if (!cfg_enabled) begin
         rx_phase  = PH_WAITING;
         quiet_run = '0;
         clear_transmit();
         reply_sel = KIND_NONE;
         return r;
      end
      if (rx_phase != PH_SENDING) begin
         if (falling || t.start_send) begin
            if (falling && edge_total != 8'hFF) edge_total++;
            rx_phase  = PH_RECEIVING;
            quiet_run = '0;
         end else if (rx_phase == PH_RECEIVING) begin
            quiet_run = quiet_run + 16'd1;
            if (quiet_run >= cfg_quiet) begin
               quiet_run = '0;
               clear_transmit();
               if (edge_total < cfg_edge_limit) begin
                  reply_sel  = calib_next ? KIND_CALIBRATION : KIND_IDENTITY;
                  calib_next = !calib_next;
               end else begin
                  reply_sel = KIND_STATUS;
                  if (t.report_valid) begin
                     held_status    = t.report_data;
                     r.report_taken = 1'b1;
                  end else begin
                     held_status = cfg_idle_report;
                  end
               end
               rx_phase = PH_SENDING;
            end
         end
      end
      if (rx_phase == PH_SENDING) begin
         case (reply_sel)
            KIND_IDENTITY: begin
               len = IDENT_BYTES;
               cur = (byte_idx < IDENT_BYTES) ? IDENT_REPLY[23 - 8 * int'(byte_idx) -: 8] : 8'h00;
            end
            KIND_CALIBRATION: begin
               len = CALIB_BYTES;
               cur = (byte_idx < CALIB_BYTES) ? CALIB_REPLY[79 - 8 * int'(byte_idx) -: 8] : 8'h00;
            end
            default: begin
               len = STATUS_BYTES;
               cur = (byte_idx < 8) ? held_status[63 - 8 * int'(byte_idx) -: 8] : 8'h00;
            end
         endcase
         bitval = (byte_idx >= len) ? 1'b1 : cur[7 - bit_idx];
         r.drive_low  = (quarter == 2'd0) || (!bitval && quarter < 2'd3);
         r.busy_res   = 1'b1;
         r.reply_kind = reply_sel;
         unit_run = unit_run + 16'd1;
         if (unit_run >= cfg_unit) begin
            unit_run = '0;
            if (quarter == 2'd3) begin
               quarter = '0;
               if (byte_idx >= len) begin
                  rx_phase   = PH_WAITING;
                  edge_total = '0;
                  clear_transmit();
                  reply_sel  = KIND_NONE;
               end else if (bit_idx == 3'd7) begin
                  bit_idx  = '0;
                  byte_idx = byte_idx + 4'd1;
               end else begin
                  bit_idx = bit_idx + 3'd1;
               end
            end else begin
               quarter = quarter + 2'd1;
            end
         end
      end
      return r;
   endfunction

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      line_tick_type t;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            t.line_level   = req_ch.line_level;
            t.start_send   = req_ch.start_send;
            t.report_valid = req_ch.report_valid;
            t.report_data  = req_ch.report_data;
            expected_wire.push_back(advance_responder(t));
            accepted_ticks++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               t = tick_queue.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.line_level   <= t.line_level;
               req_ch.start_send   <= t.start_send;
               req_ch.report_valid <= t.report_valid;
               req_ch.report_data  <= t.report_data;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result ready: stretches of always-ready, a rotating pattern, or random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_left  = $urandom_range(20, 200);
            ready_mode    = int'($urandom_range(0, 2));
            ready_pattern = 16'($urandom);
         end else begin
            stretch_left--;
         end
         case (ready_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ready_pattern[pattern_pos];
            default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         endcase
         pattern_pos = pattern_pos + 4'd1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      wire_out_type got;
      wire_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.drive_low    = rsp_ch.drive_low;
         got.report_taken = rsp_ch.report_taken;
         got.busy_res     = rsp_ch.busy_res;
         got.reply_kind   = kind_type'(rsp_ch.reply_kind);
         if (expected_wire.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no request pending", $realtime);
         end else begin
            want = expected_wire.pop_front();
            if (got.drive_low !== want.drive_low || got.report_taken !== want.report_taken ||
                got.busy_res !== want.busy_res || got.reply_kind !== want.reply_kind) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: drive/taken/busy/kind expected %b %b %b %0d, got %b %b %b %0d",
                           $realtime, want.drive_low, want.report_taken, want.busy_res,
                           want.reply_kind, got.drive_low, got.report_taken, got.busy_res,
                           got.reply_kind);
            end
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic push_tick(input logic level, input logic start, input logic rv,
                            input logic [63:0] rd);
      tick_queue.push_back('{level, start, rv, rd});
      pushed_ticks++;
   endtask

   task automatic wait_drained();
      while (accepted_ticks != pushed_ticks) @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      while (expected_wire.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_ENABLED:          cfg_enabled     = value[0];
         CSR_QUIET_TICKS:      cfg_quiet       = value[15:0];
         CSR_UNIT_TICKS:       cfg_unit        = value[15:0];
         CSR_SHORT_EDGE_LIMIT: cfg_edge_limit  = value[7:0];
         CSR_IDLE_REPORT:      cfg_idle_report = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // falling edges, optional start, then a full quiet stretch
   task automatic send_command(input int edges, input bit with_start, input bit rv,
                               input logic [63:0] rd);
      bit start_first;
      start_first = with_start && (edges == 0 || $urandom_range(0, 1) == 1);
      if (start_first) push_tick(1'b1, 1'b1, rv, rd);
      for (int i = 0; i < edges; i++) begin
         push_tick(1'b0, with_start && !start_first && i == 0, rv, rd);
         push_tick(1'b1, 1'b0, rv, rd);
      end
      for (int i = 0; i < int'(cfg_quiet); i++) push_tick(1'b1, 1'b0, rv, rd);
   endtask

   task automatic finish_reply(input bit noisy);
      wait_drained();
      while (rx_phase == PH_SENDING) begin
         repeat (8)
            push_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b1,
                      noisy ? 1'($urandom_range(0, 1)) : 1'b0,
                      1'($urandom_range(0, 1)), {$urandom, $urandom});
         wait_drained();
      end
   endtask

   // reply in progress dropped by disabling, then enabled again
   task automatic drop_reply();
      settle();
      write_reg(CSR_ENABLED, 64'd0);
      repeat (3)
         push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), {$urandom, $urandom});
      push_tick(1'b1, 1'b0, 1'b0, '0);
      settle();
      write_reg(CSR_ENABLED, 64'd1);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ENABLED;
      csr_write_data   = '0;
      req_ch.valid        = 1'b0;
      req_ch.line_level   = 1'b1;
      req_ch.start_send   = 1'b0;
      req_ch.report_valid = 1'b0;
      req_ch.report_data  = '0;
      rsp_ch.ready        = 1'b0;

      cfg_enabled     = 1'b1;
      cfg_quiet       = 16'd115;
      cfg_unit        = 16'd48;
      cfg_edge_limit  = 8'd16;
      cfg_idle_report = '0;
      rx_phase    = PH_WAITING;
      edge_total  = '0;
      quiet_run   = '0;
      clear_transmit();
      reply_sel   = KIND_NONE;
      calib_next  = 1'b0;
      held_status = '0;
      last_level  = 1'b1;
      pushed_ticks   = 0;
      accepted_ticks = 0;
      mismatches     = 0;
      burst_left     = 0;
      gap_left       = 0;
      stretch_left   = 0;
      stall_cycles   = 0;
      ready_mode     = 0;
      ready_pattern  = '1;
      pattern_pos    = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: identity after the default quiet stretch, full unit length
      send_command(1, 1'b0, 1'b0, '0);
      repeat (6) push_tick(1'b1, 1'b0, 1'b0, '0);
      drop_reply();

      // zero timing registers act as one; calibration turn, edge and start together or start first
      write_reg(CSR_QUIET_TICKS, 64'd0);
      write_reg(CSR_UNIT_TICKS, 64'd0);
      write_reg(CSR_SHORT_EDGE_LIMIT, 64'd4);
      write_reg(CSR_IDLE_REPORT, {$urandom, $urandom});
      send_command(2, 1'b1, 1'b0, '0);
      repeat (25) push_tick(1'b1, 1'b0, 1'b0, '0);
      drop_reply();

      // start alone, identity through the stop bit
      write_reg(CSR_QUIET_TICKS, 64'd3);
      write_reg(CSR_UNIT_TICKS, 64'd1);
      send_command(0, 1'b1, 1'b0, '0);
      finish_reply(1'b0);

      // offered report taken at reply start
      send_command(4, 1'b0, 1'b1, {$urandom, $urandom});
      repeat (12) push_tick(1'b1, 1'b0, 1'b1, '1);
      drop_reply();

      // idle report, edges and start during the reply ignored
      send_command(6, 1'b0, 1'b0, '0);
      finish_reply(1'b1);

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_wire.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/jcr_pkg.sv
hdl/jcr_if.sv
hdl/jcr_bit_source.sv
hdl/joybus_controller_responder_top.sv
tb/sv/testbench.sv
